// ===== rtl/hpmg_pkg.sv =====
// Shared types, codes and constants of the person proximity motion guard.
package hpmg_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int TIMER_BITS_DEF = 16;

  // Configuration register indexes
  localparam logic [2:0] REG_ROBOT_POS_X     = 3'd0;
  localparam logic [2:0] REG_ROBOT_POS_Y     = 3'd1;
  localparam logic [2:0] REG_ROBOT_RADIUS    = 3'd2;
  localparam logic [2:0] REG_STOP_HOLD_TICKS = 3'd3;
  localparam logic [2:0] REG_SPEED_HOLD_TICKS = 3'd4;

  localparam int RESET_ROBOT_POS_X  = 3021;
  localparam int RESET_ROBOT_POS_Y  = 2048;
  localparam int RESET_ROBOT_RADIUS = 1853;
  localparam int RESET_STOP_HOLD    = 4000;
  localparam int RESET_SPEED_HOLD   = 2000;

  // Item opcodes
  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Speed factor codes
  localparam logic [1:0] SPEED_FULL   = 2'd0;
  localparam logic [1:0] SPEED_SLOW   = 2'd1;
  localparam logic [1:0] SPEED_MEDIUM = 2'd2;

  // Squared speed thresholds, units of 2^-20 m^2/s^2
  localparam int SLOW_SQ = 10486;
  localparam int ONE_SQ  = 1 << 20;
  localparam int TWO_SQ  = 1 << 22;

  // Angles: 2*pi/65536 units; fine angles: 2*pi/2^20 units
  localparam int ANG_HALF     = 32768;
  localparam int ANG_QUARTER  = 16384;
  localparam int FINE_QUARTER = 1 << 18;
  localparam int Z_BITS       = 21;

  typedef logic signed [16:0] angle_t;

  typedef enum logic [3:0] {
    S_IDLE, S_VX, S_VY, S_DX, S_DY, S_MR, S_MR2, S_CMP,
    S_SQRT, S_ALPHA, S_BETA, S_GAMMA, S_DONE
  } state_t;

  function automatic logic [17:0] step_angle(input logic [3:0] i);
    logic [17:0] a;
    unique case (i)
      4'd0:  a = 18'd131072;
      4'd1:  a = 18'd77376;
      4'd2:  a = 18'd40884;
      4'd3:  a = 18'd20753;
      4'd4:  a = 18'd10417;
      4'd5:  a = 18'd5213;
      4'd6:  a = 18'd2607;
      4'd7:  a = 18'd1304;
      4'd8:  a = 18'd652;
      4'd9:  a = 18'd326;
      4'd10: a = 18'd163;
      4'd11: a = 18'd81;
      4'd12: a = 18'd41;
      4'd13: a = 18'd20;
      4'd14: a = 18'd10;
      4'd15: a = 18'd5;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/hpmg_cordic.sv =====
// Iterative vectoring CORDIC: atan2 in 2*pi/65536 units, one step per cycle.
module hpmg_cordic import hpmg_pkg::*; #(
  parameter int AB = 20
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic signed [AB:0] x,
  input  logic signed [AB:0] y,
  output logic            done,
  output angle_t          angle
);

  localparam int CW = AB + 19;

  logic signed [CW-1:0]     cx, cy, sx, sy;
  logic signed [Z_BITS-1:0] z, sa;
  logic [3:0]               idx;
  logic                     busy, fin, xneg, yneg;
  logic [AB:0]              xm, ym;
  logic [18:0]              zc;
  logic [14:0]              q;
  logic signed [16:0]       qa, qf;

  assign xm = x[AB] ? (AB+1)'(-x) : (AB+1)'(x);
  assign ym = y[AB] ? (AB+1)'(-y) : (AB+1)'(y);
  assign sx = cy >>> idx;
  assign sy = cx >>> idx;
  assign sa = signed'(Z_BITS'(step_angle(idx)));

  always_comb begin
    if (z < 0) begin
      zc = '0;
    end else if (z > FINE_QUARTER) begin
      zc = 19'(FINE_QUARTER);
    end else begin
      zc = z[18:0];
    end
    q  = 15'((20'(zc) + 20'd8) >> 4);
    qa = xneg ? (17'(ANG_HALF) - 17'(q)) : 17'(q);
    qf = yneg ? -qa : qa;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        xneg <= x[AB];
        yneg <= y[AB];
        if (y == '0) begin
          angle <= x[AB] ? 17'(ANG_HALF) : '0;
          done  <= 1'b1;
        end else if (x == '0) begin
          angle <= y[AB] ? -17'(ANG_QUARTER) : 17'(ANG_QUARTER);
          done  <= 1'b1;
        end else begin
          cx   <= signed'(CW'({xm, 16'h0000}));
          cy   <= signed'(CW'({ym, 16'h0000}));
          z    <= '0;
          idx  <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (cy >= 0) begin
          cx <= cx + sx;
          cy <= cy - sy;
          z  <= z + sa;
        end else begin
          cx <= cx - sx;
          cy <= cy + sy;
          z  <= z - sa;
        end
        idx <= idx + 4'd1;
        if (idx == 4'd15) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        angle <= qf;
        done  <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/hpmg_isqrt.sv =====
// Iterative floor integer square root, one result bit per cycle.
module hpmg_isqrt import hpmg_pkg::*; #(
  parameter int W = 46
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [W-1:0]     val,
  output logic             done,
  output logic [W/2-1:0]   root
);

  logic [W-1:0] v, r, bitm, trial;
  logic         busy;

  assign trial = r + bitm;
  assign root  = r[W/2-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v    <= val;
        r    <= '0;
        bitm <= {2'b01, {(W-2){1'b0}}};
        busy <= 1'b1;
      end else if (busy) begin
        if (v >= trial) begin
          v <= v - trial;
          r <= (r >> 1) + bitm;
        end else begin
          r <= r >> 1;
        end
        bitm <= bitm >> 2;
        if (bitm[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/human_proximity_motion_guard.sv =====
// Top level of the person proximity motion guard: sequencer, shared multiplier, timers.
//
// Each transaction on the input channel is either a person report or a time tick, and
// each gives exactly one result transaction. A tick or an unmatched report goes from idle
// straight to the done state. A matched report runs through one shared multiplier (speed
// squared, distance squared, envelope radius and its square); a report that is inside the
// envelope or moves at 2 m/s or faster then finishes. Otherwise the heading test runs: an
// integer square root of one iteration per root bit (23 iterations at the default width),
// then three passes of the iterative CORDIC unit. The block takes one item at a time; the
// result register lets the next item start while the previous result waits.
// Configuration writes are taken at any cycle and must be issued while idle.
module human_proximity_motion_guard import hpmg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [(COORD_BITS > TIMER_BITS ? COORD_BITS : TIMER_BITS)-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic                          track_matched,
  input  logic signed [COORD_BITS-1:0]  track_pos_x,
  input  logic signed [COORD_BITS-1:0]  track_pos_y,
  input  logic signed [COORD_BITS-1:0]  track_vel_x,
  input  logic signed [COORD_BITS-1:0]  track_vel_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          halt_motion,
  output logic                          hazard,
  output logic                          hold_active,
  output logic [1:0]                    speed_code,
  output logic                          resume_planning
);

  localparam int CB  = COORD_BITS;
  localparam int TB  = TIMER_BITS;
  // Above 26 bits the distance terms are scaled down before squaring
  localparam int PSH = (CB > 26) ? CB - 26 : 0;
  localparam int DMB = CB - PSH + 1;
  localparam int RB  = CB - 1 - PSH;
  localparam int MRB = RB + 4;
  localparam int MW0 = (CB > DMB) ? CB : DMB;
  localparam int MW  = (MW0 > MRB) ? MW0 : MRB;
  localparam int PW  = 2 * MW;
  localparam int WW  = PW + 8;
  localparam int RW  = WW / 2;
  localparam int AB  = RW;

  // Configuration registers
  logic signed [CB-1:0] robot_pos_x, robot_pos_y;
  logic [CB-2:0]        robot_radius;
  logic [TB-1:0]        stop_hold_ticks, speed_hold_ticks;

  // Held item
  logic                 op, matched;
  logic signed [CB-1:0] px, py, vx, vy;

  // Guard state
  logic          hold_running, slow_running, resume_flag;
  logic [TB-1:0] hold_count, slow_count;
  logic [1:0]    factor_code;
  logic          hold_running_next, slow_running_next, resume_flag_next;
  logic [TB-1:0] hold_count_next, slow_count_next, hc_inc, sc_inc;
  logic [1:0]    factor_code_next, new_code;
  logic          halt_next;

  state_t state, state_next;

  // Datapath
  logic signed [CB:0]   dx, dy, sdx, sdy, vxe, vye;
  logic [MW-1:0]        vxm, vym, sdxm, sdym, ma, mb;
  logic [CB-2:0]        rs;
  logic [3:0]           mfac;
  logic [PW-1:0]        prod;
  logic [PW:0]          s2, d2;
  logic [WW-1:0]        d100;
  logic [MRB-1:0]       mr;
  logic                 hz, close_or_fast, fire;
  angle_t               alpha, beta, co_angle;
  logic signed [17:0]   diff, adiff;

  logic                 sq_start, sq_done, co_start, co_done;
  logic [RW-1:0]        sq_root;
  logic signed [AB:0]   co_x, co_y;

  assign in_stall = (state != S_IDLE);
  assign fire     = (state == S_DONE) && (!out_valid || !out_stall);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      robot_pos_x      <= CB'(RESET_ROBOT_POS_X);
      robot_pos_y      <= CB'(RESET_ROBOT_POS_Y);
      robot_radius     <= (CB-1)'(RESET_ROBOT_RADIUS);
      stop_hold_ticks  <= TB'(RESET_STOP_HOLD);
      speed_hold_ticks <= TB'(RESET_SPEED_HOLD);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROBOT_POS_X:      robot_pos_x      <= signed'(cfg_data[CB-1:0]);
        REG_ROBOT_POS_Y:      robot_pos_y      <= signed'(cfg_data[CB-1:0]);
        REG_ROBOT_RADIUS:     robot_radius     <= cfg_data[CB-2:0];
        REG_STOP_HOLD_TICKS:  stop_hold_ticks  <= cfg_data[TB-1:0];
        REG_SPEED_HOLD_TICKS: speed_hold_ticks <= cfg_data[TB-1:0];
        default: ;
      endcase
    end
  end

  // Geometry: person-to-robot vector and magnitudes fed to the multiplier
  assign dx   = (CB+1)'(robot_pos_x) - (CB+1)'(px);
  assign dy   = (CB+1)'(robot_pos_y) - (CB+1)'(py);
  assign sdx  = dx >>> PSH;
  assign sdy  = dy >>> PSH;
  assign vxe  = (CB+1)'(vx);
  assign vye  = (CB+1)'(vy);
  assign vxm  = MW'(vxe[CB] ? -vxe : vxe);
  assign vym  = MW'(vye[CB] ? -vye : vye);
  assign sdxm = MW'(sdx[CB] ? -sdx : sdx);
  assign sdym = MW'(sdy[CB] ? -sdy : sdy);
  assign rs   = robot_radius >> PSH;

  // Envelope factor from speed: 1.5 at 1 m/s or more, 1.1 at 0.1 m/s or more
  always_comb begin
    if (s2 >= (PW+1)'(ONE_SQ)) begin
      mfac = 4'd15;
    end else if (s2 >= (PW+1)'(SLOW_SQ)) begin
      mfac = 4'd11;
    end else begin
      mfac = 4'd10;
    end
  end

  // Shared multiplier operand select
  always_comb begin
    case (state)
      S_VX:    begin ma = vxm;           mb = vxm;           end
      S_VY:    begin ma = vym;           mb = vym;           end
      S_DX:    begin ma = sdxm;          mb = sdxm;          end
      S_DY:    begin ma = sdym;          mb = sdym;          end
      S_MR:    begin ma = MW'(mfac);     mb = MW'(rs);       end
      S_MR2:   begin ma = prod[MW-1:0];  mb = prod[MW-1:0];  end
      default: begin ma = '0;            mb = '0;            end
    endcase
  end

  assign close_or_fast = (d100 <= WW'(prod)) || (s2 >= (PW+1)'(TWO_SQ));

  // CORDIC operands: velocity, then robot direction, then half-cone width
  always_comb begin
    case (state)
      S_SQRT:  begin co_x = (AB+1)'(vx);            co_y = (AB+1)'(vy);           end
      S_ALPHA: begin co_x = (AB+1)'(dx);            co_y = (AB+1)'(dy);           end
      default: begin co_x = signed'((AB+1)'(sq_root)); co_y = signed'((AB+1)'(mr)); end
    endcase
  end

  assign sq_start = (state == S_CMP) && !close_or_fast;
  assign co_start = ((state == S_SQRT) && sq_done) || ((state == S_ALPHA) && co_done) ||
                    ((state == S_BETA) && co_done);

  assign diff  = 18'(alpha) - 18'(beta);
  assign adiff = diff[17] ? -diff : diff;

  hpmg_isqrt #(.W(WW)) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .val   (d100 - WW'(prod)),
    .done  (sq_done),
    .root  (sq_root)
  );

  hpmg_cordic #(.AB(AB)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (co_start),
    .x     (co_x),
    .y     (co_y),
    .done  (co_done),
    .angle (co_angle)
  );

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (opcode == OP_TICK || !track_matched) ? S_DONE : S_VX;
        end
      end
      S_VX:    state_next = S_VY;
      S_VY:    state_next = S_DX;
      S_DX:    state_next = S_DY;
      S_DY:    state_next = S_MR;
      S_MR:    state_next = S_MR2;
      S_MR2:   state_next = S_CMP;
      S_CMP:   state_next = close_or_fast ? S_DONE : S_SQRT;
      S_SQRT:  if (sq_done) state_next = S_ALPHA;
      S_ALPHA: if (co_done) state_next = S_BETA;
      S_BETA:  if (co_done) state_next = S_GAMMA;
      S_GAMMA: if (co_done) state_next = S_DONE;
      S_DONE:  if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod <= PW'(ma) * PW'(mb);
    case (state)
      S_IDLE: begin
        op      <= opcode;
        matched <= track_matched;
        px      <= track_pos_x;
        py      <= track_pos_y;
        vx      <= track_vel_x;
        vy      <= track_vel_y;
        hz      <= 1'b0;
      end
      S_VY:  s2 <= (PW+1)'(prod);
      S_DX:  s2 <= s2 + (PW+1)'(prod);
      S_DY:  d2 <= (PW+1)'(prod);
      S_MR:  d2 <= d2 + (PW+1)'(prod);
      S_MR2: begin
        mr   <= prod[MRB-1:0];
        d100 <= (WW'(d2) << 6) + (WW'(d2) << 5) + (WW'(d2) << 2);
      end
      S_CMP: if (close_or_fast) hz <= 1'b1;
      S_ALPHA: if (co_done) alpha <= co_angle;
      S_BETA:  if (co_done) beta <= co_angle;
      S_GAMMA: if (co_done) hz <= (adiff <= 18'(co_angle));
      default: ;
    endcase
  end

  // Guard state update at the close of an item
  assign sc_inc   = slow_count + TB'(1);
  assign hc_inc   = hold_count + TB'(1);
  assign new_code = (s2 < (PW+1)'(SLOW_SQ)) ? SPEED_SLOW : SPEED_MEDIUM;

  always_comb begin
    hold_running_next = hold_running;
    hold_count_next   = hold_count;
    slow_running_next = slow_running;
    slow_count_next   = slow_count;
    factor_code_next  = factor_code;
    resume_flag_next  = resume_flag;
    halt_next         = 1'b0;
    if (op == OP_TICK) begin
      // Speed timer first, then hold timer
      if (slow_running) begin
        slow_count_next = sc_inc;
        if (sc_inc >= speed_hold_ticks) begin
          slow_running_next = 1'b0;
          if (!hold_running) begin
            factor_code_next = SPEED_FULL;
            resume_flag_next = 1'b1;
          end
        end
      end
      if (hold_running) begin
        hold_count_next = hc_inc;
        if (hc_inc >= stop_hold_ticks) begin
          hold_running_next = 1'b0;
          factor_code_next  = SPEED_SLOW;
          resume_flag_next  = 1'b1;
          slow_running_next = 1'b1;
          slow_count_next   = '0;
        end
      end
    end else if (matched) begin
      if (hz) begin
        if (!hold_running) begin
          halt_next        = 1'b1;
          resume_flag_next = 1'b0;
        end
        hold_running_next = 1'b1;
        hold_count_next   = '0;
      end else if (!hold_running && new_code != factor_code) begin
        // Code change: halt for replanning, restart speed timer
        factor_code_next  = new_code;
        halt_next         = 1'b1;
        slow_running_next = 1'b1;
        slow_count_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_running <= 1'b1;
      hold_count   <= '0;
      slow_running <= 1'b1;
      slow_count   <= '0;
      factor_code  <= SPEED_FULL;
      resume_flag  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (fire) begin
        hold_running <= hold_running_next;
        hold_count   <= hold_count_next;
        slow_running <= slow_running_next;
        slow_count   <= slow_count_next;
        factor_code  <= factor_code_next;
        resume_flag  <= resume_flag_next;
        out_valid    <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register; hold while stalled
  always_ff @(posedge clk) begin
    if (fire) begin
      halt_motion     <= halt_next;
      hazard          <= hz;
      hold_active     <= hold_running_next;
      speed_code      <= factor_code_next;
      resume_planning <= resume_flag_next;
    end
  end

  // A hazard always leaves the hold timer running
  a_hazard_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && hazard |-> hold_active)
    else $error("hazard result without hold");

  // A halt caused by a hazard drops the resume permission
  a_halt_clears_resume: assert property (@(posedge clk) disable iff (rst)
    out_valid && hazard && halt_motion |-> !resume_planning)
    else $error("hazard halt with resume set");

  // Speed code stays within its three factors
  a_speed_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> speed_code != 2'd3)
    else $error("invalid speed code");

  // An accepted transaction moves the sequencer out of idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != S_IDLE)
    else $error("accepted transaction left sequencer idle");

endmodule

// ===== verif/human_proximity_motion_guard_tb.sv =====
// Testbench of the person proximity motion guard: directed and random traffic, scoreboard.
module human_proximity_motion_guard_tb;
  import hpmg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  // Allow for the slowest report (square root plus three CORDIC passes) and some margin.
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic       halt_motion;
    logic       hazard;
    logic       hold_active;
    logic [1:0] speed_code;
    logic       resume_planning;
  } verdict_t;

  // CORDIC step angles in fine units (2*pi/2^20)
  localparam longint ATAN_STEP [16] = '{
    131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
    652, 326, 163, 81, 41, 20, 10, 5
  };

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               opcode;
  logic               track_matched;
  logic signed [15:0] track_pos_x;
  logic signed [15:0] track_pos_y;
  logic signed [15:0] track_vel_x;
  logic signed [15:0] track_vel_y;
  logic               out_valid;
  logic               out_stall;
  logic               halt_motion;
  logic               hazard;
  logic               hold_active;
  logic [1:0]         speed_code;
  logic               resume_planning;

  human_proximity_motion_guard i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .track_matched(track_matched),
    .track_pos_x(track_pos_x), .track_pos_y(track_pos_y),
    .track_vel_x(track_vel_x), .track_vel_y(track_vel_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .halt_motion(halt_motion), .hazard(hazard), .hold_active(hold_active),
    .speed_code(speed_code), .resume_planning(resume_planning)
  );

  // Mirror of the guard's configuration and state
  longint     zone_x, zone_y, zone_r;
  longint     hold_len, slow_len;
  bit         hold_on, slow_on, resume_on;
  longint     hold_ticks, slow_ticks;
  logic [1:0] factor_now;

  verdict_t expected_verdicts[$];
  int       mismatches;
  int       verdicts_seen;
  int       hazards_seen;
  int       halts_seen;
  int       ticks_sent;
  int       reports_sent;
  longint   cycle_count;
  bit       sender_calm;
  bit       receiver_calm;
  int       stall_left;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic longint magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Quadrant-mapped CORDIC angle in 2*pi/65536 units, axis vectors exact.
  function automatic longint heading_of(longint x, longint y);
    longint cx, cy, z, q, sx, sy;
    if (y == 0) return x < 0 ? ANG_HALF : 0;
    if (x == 0) return y > 0 ? ANG_QUARTER : -ANG_QUARTER;
    cx = magnitude(x) <<< 16;
    cy = magnitude(y) <<< 16;
    z = 0;
    for (int i = 0; i < 16; i++) begin
      sx = cy >>> i;
      sy = cx >>> i;
      if (cy >= 0) begin
        cx += sx; cy -= sy; z += ATAN_STEP[i];
      end else begin
        cx -= sx; cy += sy; z -= ATAN_STEP[i];
      end
    end
    if (z < 0) z = 0;
    if (z > FINE_QUARTER) z = FINE_QUARTER;
    q = (z + 8) >>> 4;
    if (x < 0) q = ANG_HALF - q;
    return y < 0 ? -q : q;
  endfunction

  function automatic longint floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // Stop condition: inside the widened envelope, too fast, or heading at the robot.
  function automatic bit is_hazard(longint px, longint py, longint vx, longint vy,
                                   longint s2);
    longint dx, dy, m, d100, e100, alpha, beta, gamma, diff;
    dx = zone_x - px;
    dy = zone_y - py;
    m = 10;
    if (s2 >= ONE_SQ) m = 15;
    else if (s2 >= SLOW_SQ) m = 11;
    d100 = 100 * (dx * dx + dy * dy);
    e100 = m * m * zone_r * zone_r;
    if (d100 <= e100) return 1'b1;
    if (s2 >= TWO_SQ) return 1'b1;
    alpha = heading_of(vx, vy);
    beta = heading_of(dx, dy);
    gamma = heading_of(floor_root(d100 - e100), m * zone_r);
    diff = magnitude(alpha - beta);
    return diff <= gamma;
  endfunction

  function automatic void restore_defaults();
    zone_x = RESET_ROBOT_POS_X;
    zone_y = RESET_ROBOT_POS_Y;
    zone_r = RESET_ROBOT_RADIUS;
    hold_len = RESET_STOP_HOLD;
    slow_len = RESET_SPEED_HOLD;
    hold_on = 1'b1;
    hold_ticks = 0;
    slow_on = 1'b1;
    slow_ticks = 0;
    factor_now = SPEED_FULL;
    resume_on = 1'b0;
  endfunction

  // Advance the mirrored state by one accepted transaction and return its result.
  function automatic verdict_t guard_predict(logic op, logic matched, logic signed [15:0] px,
                                             logic signed [15:0] py, logic signed [15:0] vx,
                                             logic signed [15:0] vy);
    verdict_t v;
    longint s2;
    logic [1:0] code;
    v = '0;
    if (op == OP_TICK) begin
      if (slow_on) begin
        slow_ticks = (slow_ticks + 1) & 16'hffff;
        if (slow_ticks >= slow_len) begin
          slow_on = 1'b0;
          if (!hold_on) begin
            factor_now = SPEED_FULL;
            resume_on = 1'b1;
          end
        end
      end
      if (hold_on) begin
        hold_ticks = (hold_ticks + 1) & 16'hffff;
        if (hold_ticks >= hold_len) begin
          hold_on = 1'b0;
          factor_now = SPEED_SLOW;
          resume_on = 1'b1;
          slow_on = 1'b1;
          slow_ticks = 0;
        end
      end
    end else if (matched) begin
      s2 = longint'(vx) * vx + longint'(vy) * vy;
      if (is_hazard(px, py, vx, vy, s2)) begin
        v.hazard = 1'b1;
        if (!hold_on) begin
          v.halt_motion = 1'b1;
          resume_on = 1'b0;
        end
        hold_on = 1'b1;
        hold_ticks = 0;
      end else if (!hold_on) begin
        code = s2 < SLOW_SQ ? SPEED_SLOW : SPEED_MEDIUM;
        if (code != factor_now) begin
          factor_now = code;
          v.halt_motion = 1'b1;
          slow_on = 1'b1;
          slow_ticks = 0;
        end
      end
    end
    v.hold_active = hold_on;
    v.speed_code = factor_now;
    v.resume_planning = resume_on;
    return v;
  endfunction

  // Write one register at the next edge; write enable stays high for the next write.
  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_ROBOT_POS_X:      zone_x = longint'($signed(value));
      REG_ROBOT_POS_Y:      zone_y = longint'($signed(value));
      REG_ROBOT_RADIUS:     zone_r = value[14:0];
      REG_STOP_HOLD_TICKS:  hold_len = value;
      REG_SPEED_HOLD_TICKS: slow_len = value;
      default: ;
    endcase
  endtask

  // Write all registers back to back; callers make sure the guard is idle.
  task automatic write_zone(logic [15:0] x, logic [15:0] y, logic [15:0] r,
                            logic [15:0] hold, logic [15:0] slow);
    write_reg(REG_ROBOT_POS_X, x);
    write_reg(REG_ROBOT_POS_Y, y);
    write_reg(REG_ROBOT_RADIUS, r);
    write_reg(REG_STOP_HOLD_TICKS, hold);
    write_reg(REG_SPEED_HOLD_TICKS, slow);
    cfg_we <= 1'b0;
  endtask

  // Wait until every result has come back, then let the pipeline settle.
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Send one transaction; valid stays high afterwards so back-to-back items need no gap.
  task automatic send_item(logic op, logic matched, logic [15:0] px, logic [15:0] py,
                           logic [15:0] vx, logic [15:0] vy);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    track_matched <= matched;
    track_pos_x <= px;
    track_pos_y <= py;
    track_vel_x <= vx;
    track_vel_y <= vy;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_verdicts.push_back(guard_predict(op, matched, px, py, vx, vy));
    if (op == OP_TICK) ticks_sent++;
    else reports_sent++;
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  task automatic send_report(logic [15:0] px, logic [15:0] py, logic [15:0] vx,
                             logic [15:0] vy);
    send_item(OP_REPORT, 1'b1, px, py, vx, vy);
  endtask

  // Score each result against the oldest prediction; stall the receiver at random.
  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        verdicts_seen++;
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result transaction");
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          if (halt_motion !== want.halt_motion) begin
            $error("halt_motion expected %0d actual %0d", want.halt_motion, halt_motion);
            mismatches++;
          end
          if (hazard !== want.hazard) begin
            $error("hazard expected %0d actual %0d", want.hazard, hazard);
            mismatches++;
          end
          if (hold_active !== want.hold_active) begin
            $error("hold_active expected %0d actual %0d", want.hold_active, hold_active);
            mismatches++;
          end
          if (speed_code !== want.speed_code) begin
            $error("speed_code expected %0d actual %0d", want.speed_code, speed_code);
            mismatches++;
          end
          if (resume_planning !== want.resume_planning) begin
            $error("resume_planning expected %0d actual %0d", want.resume_planning,
                   resume_planning);
            mismatches++;
          end
          if (want.hazard) hazards_seen++;
          if (want.halt_motion) halts_seen++;
        end
        // Draw the stall ahead of the next result.
        stall_left = receiver_calm ? 0 : $urandom_range(0, 19);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_verdicts.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Directed: reset settings, inside zone, speed limits, heading, axes, field extremes.
  task automatic test_directed();
    // With reset timers the hold is running: hazards and codes are held.
    send_tick();
    send_item(OP_REPORT, 1'b0, 16'sd3021, 16'sd2048, 16'sd0, 16'sd0);
    send_report(16'sd3021, 16'sd2048, 16'sd0, 16'sd0);
    drain();
    // Short hold so the timers expire within a few ticks.
    write_zone(16'sd3021, 16'sd2048, 16'd1853, 16'd2, 16'd3);
    send_tick();
    send_tick();
    // Far away and standing still: slow code; zero velocity reads as heading at the robot, so a hazard.
    send_report(-16'sd20000, 16'sd2048, 16'sd0, 16'sd0);
    // Walking away slowly at medium speed: the hold is running, so the code is left alone.
    send_report(-16'sd20000, 16'sd2048, -16'sd300, 16'sd0);
    // Walking straight at the robot along the x axis.
    send_report(-16'sd20000, 16'sd2048, 16'sd300, 16'sd0);
    // Hold running and no hazard: code left alone.
    send_report(-16'sd20000, 16'sd2048, -16'sd50, 16'sd0);
    repeat (3) send_tick();
    // Speed at exactly 2 m/s far away, then just under it going away.
    send_report(16'h8000, 16'h8000, 16'sd0, -16'sd2048);
    repeat (3) send_tick();
    send_report(16'sd32767, 16'sd32767, 16'sd2047, 16'sd0);
    // Field extremes for velocities and positions.
    send_report(16'sd32767, 16'h8000, 16'h8000, 16'sd32767);
    repeat (4) send_tick();
    send_report(16'h8000, 16'sd32767, 16'sd0, 16'sd1);
    send_report(16'sd32767, 16'sd2048, 16'sd0, -16'sd200);
    send_report(16'sd3021, 16'sd32767, 16'sd40, -16'sd1);
    // Right at the edge of the envelope.
    send_report(16'sd3021 + 16'sd1853, 16'sd2048, 16'sd0, 16'sd0);
    send_report(16'sd3021 + 16'sd1854, 16'sd2048, 16'sd0, 16'sd0);
    drain();
  endtask

  // Sweep settings through their extremes, including zero tick lengths.
  task automatic test_config_extremes();
    logic [15:0] xs[4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    foreach (xs[k]) begin
      write_zone(xs[k], xs[3 - k], (k % 2) ? 16'h7fff : 16'h0000,
                 (k < 2) ? 16'd0 : 16'd1, (k < 2) ? 16'd1 : 16'd0);
      repeat (3) send_tick();
      repeat (4) send_report(16'($urandom), 16'($urandom),
                             $urandom_range(0, 1) ? 16'($urandom) : 16'd0,
                             16'($urandom_range(0, 7)));
      repeat (2) send_tick();
      drain();
    end
    // Longest hold: no running timer expires in this phase.
    write_zone(16'sd3021, 16'sd2048, 16'd1853, 16'hffff, 16'hffff);
    repeat (10) send_tick();
    repeat (5) send_report(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    drain();
  endtask

  // Random phases: small zones and short timers reach hold expiry and code changes.
  task automatic test_random_traffic(int items);
    int sent;
    int kind;
    int phase;
    logic signed [15:0] px, py, vx, vy;
    longint dx, dy;
    sent = 0;
    phase = 0;
    while (sent < items) begin
      write_zone(16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8191) - 4096),
                 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8191) - 4096),
                 16'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 3000)),
                 16'($urandom_range(0, 6) == 0 ? $urandom : $urandom_range(0, 12)),
                 16'($urandom_range(0, 6) == 0 ? $urandom : $urandom_range(0, 12)));
      // Alternate idle patterns so gaps and back-to-back runs both show up.
      sender_calm = (phase % 4 == 1);
      receiver_calm = (phase % 4 == 2);
      for (int n = 0; n < 100 && sent < items; n++) begin
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
          send_tick();
        end else if (kind < 40) begin
          send_item(OP_REPORT, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom));
        end else if (kind < 48) begin
          // Noise: any bit pattern.
          send_report(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
          px = 16'(zone_x + $urandom_range(0, 16383) - 8192);
          py = 16'(zone_y + $urandom_range(0, 16383) - 8192);
          dx = zone_x - px;
          dy = zone_y - py;
          case ($urandom_range(0, 4))
            0: begin vx = '0; vy = '0; end
            1: begin
              vx = 16'($urandom_range(0, 200) - 100);
              vy = 16'($urandom_range(0, 200) - 100);
            end
            2: begin
              vx = 16'($urandom_range(0, 2000) - 1000);
              vy = 16'($urandom_range(0, 2000) - 1000);
            end
            3: begin
              // Head roughly toward the robot.
              vx = 16'((dx >>> $urandom_range(2, 5)) + $urandom_range(0, 60) - 30);
              vy = 16'((dy >>> $urandom_range(2, 5)) + $urandom_range(0, 60) - 30);
            end
            default: begin
              vx = 16'($urandom_range(0, 5000) - 2500);
              vy = 16'($urandom_range(0, 5000) - 2500);
            end
          endcase
          send_report(px, py, vx, vy);
        end
        sent++;
        // Now and then hold off the sender until the guard has answered everything.
        if ($urandom_range(0, 199) == 0) begin
          in_valid <= 1'b0;
          while (expected_verdicts.size() != 0) @(posedge clk);
        end
      end
      drain();
      phase++;
    end
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_ROBOT_POS_X;
    cfg_data = '0;
    in_valid = 1'b0;
    opcode = OP_REPORT;
    track_matched = 1'b0;
    track_pos_x = '0;
    track_pos_y = '0;
    track_vel_x = '0;
    track_vel_y = '0;
    mismatches = 0;
    verdicts_seen = 0;
    hazards_seen = 0;
    halts_seen = 0;
    ticks_sent = 0;
    reports_sent = 0;
    cycle_count = 0;
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
    restore_defaults();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_config_extremes();
    test_random_traffic(1600);

    drain();
    $display("covered %0d ticks and %0d reports, %0d results checked", ticks_sent,
             reports_sent, verdicts_seen);
    $display("%0d hazards and %0d halts seen across zone and timer settings", hazards_seen,
             halts_seen);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hpmg_pkg.sv
rtl/hpmg_cordic.sv
rtl/hpmg_isqrt.sv
rtl/human_proximity_motion_guard.sv
verif/human_proximity_motion_guard_tb.sv
